// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tlr_pkg.sv =====
// Shared types and constants for the telnet line receiver.
// No dependencies; imported by every module of the block.
package tlr_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int MAX_RES = 4;
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int RES_IDX_W = $clog2(MAX_RES);

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;

   localparam logic [1:0] REG_LINE_LENGTH = 2'd0;
   localparam logic [1:0] REG_WAIT_MODE   = 2'd1;

   localparam logic [11:0] LINE_LENGTH_RESET = 12'd1024;

   typedef struct packed {
      logic [11:0] line_length;
      logic        wait_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       done;
   } result_type;

   // All results caused by one accepted byte; count is 1..MAX_RES.
   typedef struct packed {
      logic [RES_CNT_W-1:0]          count;
      result_type [MAX_RES-1:0]      res;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type head;
   } qhead_type;

endpackage

// ===== src/telnet_line_receiver.sv =====
// Telnet line receiver: sorts a received byte stream into line data and
// option negotiation replies. Depends on tlr_pkg, tlr_front, tlr_queue,
// tlr_back and assert_macros.svh.
//
// Usage:
//  - req_* : one received byte per transfer (req_rx_byte, req_chunk_end);
//    a transfer happens on a rising edge with req_valid high and req_stall low.
//  - rsp_* : results, one per transfer, same valid/stall rule; rsp_last marks
//    the final result of one input byte. Bytes that cause nothing (CR, IAC,
//    the command byte, unknown-command options) produce no result.
//  - csr_* : register writes (index 0 line_length, 1 wait_mode); csr_ready is
//    always high. Write only while the block is idle.
// The first result of a byte goes through the descriptor queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// rsp_stall stays low; a negotiation reply yields three or four results, absorbed
// by the four-entry descriptor queue. req_stall rises only when that queue is full,
// so a stalled receiver backs up into the input after four descriptors wait.
// Reset: parser to plain data, line count and saved command cleared,
// line_length back to 1024 and wait_mode to 0, queue and output emptied.
module telnet_line_receiver (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_chunk_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_line_done,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import tlr_pkg::*;
   `include "assert_macros.svh"

   cfg_type    cfg_ff, cfg_in;
   logic       fire;
   logic       push;
   logic       pop;
   logic       q_full;
   desc_type   push_desc;
   qhead_type  q_head;

   // config registers; writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LINE_LENGTH: cfg_in.line_length = csr_wdata;
            REG_WAIT_MODE:   cfg_in.wait_mode   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length <= LINE_LENGTH_RESET;
         cfg_ff.wait_mode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer whenever the queue has room
   assign req_stall = q_full;
   assign fire      = req_valid && !q_full;

   tlr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .rx_byte   (req_rx_byte),
      .chunk_end (req_chunk_end),
      .push      (push),
      .desc      (push_desc)
   );

   tlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (q_head),
      .full      (q_full)
   );

   tlr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_line_done (rsp_line_done),
      .rsp_last      (rsp_last)
   );

   // results of one byte come out without gaps
   `ASSERT_CLK(a_burst_gapless, clock, reset, (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid, "gap inside a result burst")
   // a bare line end always closes the line
   `ASSERT_CLK(a_end_done, clock, reset, (rsp_valid && rsp_out_kind == KIND_END) |-> rsp_line_done, "line end without line_done")
   // reply bytes never close a line
   `ASSERT_CLK(a_reply_open, clock, reset, (rsp_valid && rsp_out_kind == KIND_REPLY) |-> !rsp_line_done, "reply byte with line_done")
   // never push into a full queue
   `ASSERT_CLK(a_no_overflow, clock, reset, !(push && q_full), "descriptor queue overflow")

endmodule

// ===== src/tlr_front.sv =====
// Front end: telnet parser, line counter and result descriptor builder.
// Depends on tlr_pkg; feeds tlr_queue.
module tlr_front (
   input  logic              clock,
   input  logic              reset,
   input  tlr_pkg::cfg_type  cfg,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  logic              chunk_end,
   output logic              push,
   output tlr_pkg::desc_type desc
);
   import tlr_pkg::*;

   localparam logic [7:0] CH_IAC  = 8'd255;
   localparam logic [7:0] CH_DONT = 8'd254;
   localparam logic [7:0] CH_DO   = 8'd253;
   localparam logic [7:0] CH_WONT = 8'd252;
   localparam logic [7:0] CH_WILL = 8'd251;
   localparam logic [7:0] CH_NUL  = 8'd0;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   typedef enum logic [2:0] {
      ST_DATA = 3'b001,
      ST_CMD  = 3'b010,
      ST_OPT  = 3'b100
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [7:0]      saved_ff, saved_in;
   logic [11:0]     count_ff, count_in;

   logic [11:0]     count_inc;
   logic [7:0]      reply;
   logic            send;
   logic            opt_ok;
   logic            ended;
   logic [RES_CNT_W-1:0] n;

   always_comb begin
      state_in  = state_ff;
      saved_in  = saved_ff;
      count_in  = count_ff;
      count_inc = count_ff + 12'd1;
      opt_ok    = rx_byte inside {OPT_ECHO, OPT_SGA};
      reply     = 8'd0;
      send      = 1'b0;
      ended     = 1'b0;
      n         = '0;
      desc      = '0;

      case (state_ff)
         ST_CMD: begin
            saved_in = rx_byte;
            state_in = ST_OPT;
         end
         ST_OPT: begin
            send = 1'b1;
            case (saved_ff)
               CH_WILL: reply = opt_ok ? CH_DO : CH_DONT;
               CH_DO:   reply = opt_ok ? CH_WILL : CH_WONT;
               CH_WONT: reply = CH_DONT;
               CH_DONT: reply = CH_WONT;
               default: send = 1'b0;
            endcase
            if (send) begin
               desc.res[0] = '{kind: KIND_REPLY, data: CH_IAC,  done: 1'b0};
               desc.res[1] = '{kind: KIND_REPLY, data: reply,   done: 1'b0};
               desc.res[2] = '{kind: KIND_REPLY, data: rx_byte, done: 1'b0};
               n = RES_CNT_W'(3);
            end
            state_in = ST_DATA;
         end
         default: begin
            case (rx_byte)
               CH_IAC: state_in = ST_CMD;
               CH_NUL: begin
                  desc.res[0] = '{kind: KIND_END, data: 8'd0, done: 1'b1};
                  n = RES_CNT_W'(1);
                  ended = 1'b1;
               end
               CH_LF: begin
                  desc.res[0] = '{kind: KIND_DATA, data: rx_byte, done: 1'b1};
                  n = RES_CNT_W'(1);
                  ended = 1'b1;
               end
               CH_CR: ;
               default: begin
                  count_in = count_inc;
                  ended = (count_inc == cfg.line_length);
                  desc.res[0] = '{kind: KIND_DATA, data: rx_byte, done: ended};
                  n = RES_CNT_W'(1);
               end
            endcase
         end
      endcase

      if (ended) begin
         state_in = ST_DATA;
         saved_in = 8'd0;
         count_in = 12'd0;
      end else if (chunk_end && !cfg.wait_mode && count_in != 12'd0) begin
         // partial line closed at end of burst unless wait_mode; lands after any other result
         desc.res[n[RES_IDX_W-1:0]] = '{kind: KIND_END, data: 8'd0, done: 1'b1};
         n = n + RES_CNT_W'(1);
         state_in = ST_DATA;
         saved_in = 8'd0;
         count_in = 12'd0;
      end

      desc.count = n;
   end

   assign push = fire && (n != RES_CNT_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         saved_ff <= 8'd0;
         count_ff <= 12'd0;
      end else if (fire) begin
         state_ff <= state_in;
         saved_ff <= saved_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/tlr_queue.sv =====
// Short descriptor FIFO between the parser and the output sequencer.
// Depends on tlr_pkg.
module tlr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tlr_pkg::desc_type   push_desc,
   input  logic                pop,
   output tlr_pkg::qhead_type  head,
   output logic                full
);
   import tlr_pkg::*;

   desc_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/tlr_back.sv =====
// Back end: walks each descriptor, one result per transfer, into the
// output register. Depends on tlr_pkg; reads tlr_queue.
module tlr_back (
   input  logic               clock,
   input  logic               reset,
   input  tlr_pkg::qhead_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_kind,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_line_done,
   output logic               rsp_last
);
   import tlr_pkg::*;

   logic                  valid_ff, valid_in;
   logic [RES_IDX_W-1:0]  idx_ff, idx_in;
   result_type            res_ff;
   logic                  last_ff;
   logic                  load;
   logic                  at_last;

   assign load    = head.valid && (!valid_ff || !rsp_stall);
   assign at_last = ({1'b0, idx_ff} == (head.head.count - RES_CNT_W'(1)));
   assign pop     = load && at_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.head.res[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_kind  = res_ff.kind;
   assign rsp_out_byte  = res_ff.data;
   assign rsp_line_done = res_ff.done;
   assign rsp_last      = last_ff;

endmodule
